// ===== hw/rtl/itoa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg - shared types and constants for the integer to ASCII formatter
// Control word layout, microcode field codes, status flags and character codes.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // format selector codes
  localparam logic [1:0] FMT_SDEC = 2'd0;
  localparam logic [1:0] FMT_UDEC = 2'd1;
  localparam logic [1:0] FMT_HEX  = 2'd2;

  // digit stack depth: ten decimal digits at most
  localparam int unsigned StackDepth = 10;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);

  // microprogram step counter
  localparam int unsigned StepW = 4;

  // divide by ten: q = (x * RECIP10) >> 35, exact for all 32-bit x
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int unsigned RecipShf = 35;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // character source select
  localparam logic [2:0] CS_NONE  = 3'd0;
  localparam logic [2:0] CS_ZERO  = 3'd1;
  localparam logic [2:0] CS_X     = 3'd2;
  localparam logic [2:0] CS_MINUS = 3'd3;
  localparam logic [2:0] CS_SPACE = 3'd4;
  localparam logic [2:0] CS_DIGIT = 3'd5;

  // datapath operation
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_NEG  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_REM  = 3'd4;
  localparam logic [2:0] OP_HEX  = 3'd5;
  localparam logic [2:0] OP_POP  = 3'd6;

  // jump condition
  localparam logic [3:0] C_NEVER  = 4'd0;
  localparam logic [3:0] C_ALWAYS = 4'd1;
  localparam logic [3:0] C_INVAL  = 4'd2;
  localparam logic [3:0] C_HEX    = 4'd3;
  localparam logic [3:0] C_NEG    = 4'd4;
  localparam logic [3:0] C_MAGNZ  = 4'd5;
  localparam logic [3:0] C_QNZ    = 4'd6;
  localparam logic [3:0] C_HNZ    = 4'd7;
  localparam logic [3:0] C_SPGT1  = 4'd8;

  // named steps the sequencer refers to
  localparam logic [StepW-1:0] ST_IDLE = 4'd0;

  typedef struct packed {
    logic [2:0]       csel;
    logic             last;
    logic [2:0]       op;
    logic [3:0]       cond;
    logic             inv;
    logic [StepW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic is_hex;
    logic is_neg;
    logic mag_nz;
    logic q_nz;
    logic hex_nz;
    logic sp_gt1;
  } dp_flags_t;

  // nibble to uppercase hex/decimal digit
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = 8'h37 + {4'd0, d};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/itoa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_if - valid/ready channels of the formatter
// Request channel (format and value) and character channel (char and last).
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/itoa_ucode_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_ucode_rom - control store of the formatter
// One control word per step: character to emit, datapath op and jump.
// ----------------------------------------------------------------------------
module itoa_ucode_rom (
  input  wire logic [itoa_pkg::StepW-1:0] step,
  output itoa_pkg::uword_t                uword
);

  // program listing
  always_comb begin
    uword = '{csel: itoa_pkg::CS_NONE, last: 1'b0, op: itoa_pkg::OP_NOP,
              cond: itoa_pkg::C_NEVER, inv: 1'b0, target: itoa_pkg::ST_IDLE};
    case (step)
      // wait for an item, load it
      4'd0: begin
        uword.op     = itoa_pkg::OP_LOAD;
        uword.cond   = itoa_pkg::C_INVAL;
        uword.inv    = 1'b1;
        uword.target = 4'd0;
      end
      // branch to hex
      4'd1: begin
        uword.cond   = itoa_pkg::C_HEX;
        uword.target = 4'd11;
      end
      // skip sign unless negative signed
      4'd2: begin
        uword.cond   = itoa_pkg::C_NEG;
        uword.inv    = 1'b1;
        uword.target = 4'd4;
      end
      4'd3: begin
        uword.csel = itoa_pkg::CS_MINUS;
        uword.op   = itoa_pkg::OP_NEG;
      end
      // nonzero magnitude goes to the divide loop
      4'd4: begin
        uword.cond   = itoa_pkg::C_MAGNZ;
        uword.target = 4'd7;
      end
      4'd5: begin
        uword.csel = itoa_pkg::CS_SPACE;
      end
      // zero digit, shared by decimal and hex zero
      4'd6: begin
        uword.csel   = itoa_pkg::CS_ZERO;
        uword.cond   = itoa_pkg::C_ALWAYS;
        uword.target = 4'd10;
      end
      4'd7: begin
        uword.op = itoa_pkg::OP_DIV;
      end
      // push remainder, loop while the quotient is nonzero
      4'd8: begin
        uword.op     = itoa_pkg::OP_REM;
        uword.cond   = itoa_pkg::C_QNZ;
        uword.target = 4'd7;
      end
      // pop digits, most significant first
      4'd9: begin
        uword.csel   = itoa_pkg::CS_DIGIT;
        uword.op     = itoa_pkg::OP_POP;
        uword.cond   = itoa_pkg::C_SPGT1;
        uword.target = 4'd9;
      end
      // trailing space closes the run
      4'd10: begin
        uword.csel   = itoa_pkg::CS_SPACE;
        uword.last   = 1'b1;
        uword.cond   = itoa_pkg::C_ALWAYS;
        uword.target = itoa_pkg::ST_IDLE;
      end
      4'd11: begin
        uword.csel = itoa_pkg::CS_ZERO;
      end
      4'd12: begin
        uword.csel = itoa_pkg::CS_X;
      end
      4'd13: begin
        uword.cond   = itoa_pkg::C_MAGNZ;
        uword.inv    = 1'b1;
        uword.target = 4'd6;
      end
      // push nibbles while higher ones remain
      4'd14: begin
        uword.op     = itoa_pkg::OP_HEX;
        uword.cond   = itoa_pkg::C_HNZ;
        uword.target = 4'd14;
      end
      4'd15: begin
        uword.cond   = itoa_pkg::C_ALWAYS;
        uword.target = 4'd9;
      end
      default: begin
        uword.cond   = itoa_pkg::C_ALWAYS;
        uword.target = itoa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/itoa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_datapath - magnitude register, divide-by-ten unit and digit stack
// Executes one datapath op per step and reports flags to the sequencer.
// ----------------------------------------------------------------------------
module itoa_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step_en,
  input  wire logic                     in_fire,
  input  wire logic [1:0]               req_type,
  input  wire logic [31:0]              value,
  input  itoa_pkg::uword_t              uword,
  output itoa_pkg::dp_flags_t           flags,
  output logic [7:0]                    char_sel,
  output logic [itoa_pkg::SpW-1:0]      sp_o
);

  localparam int unsigned QW = 64 - itoa_pkg::RecipShf;

  logic [1:0]                 sel_r;
  logic [31:0]                mag_r;
  logic [QW-1:0]              q_r;
  logic [3:0]                 stk_r [itoa_pkg::StackDepth];
  logic [itoa_pkg::SpW-1:0]   sp_r;
  logic [itoa_pkg::SpW-1:0]   sp_nxt;
  logic [itoa_pkg::SpW-1:0]   top_idx;
  logic [63:0]                prod;
  logic [31:0]                tens;
  logic [31:0]                rem;
  logic                       push;
  logic [3:0]                 push_val;

  // reciprocal multiply, remainder from the registered quotient
  assign prod     = 64'(mag_r) * 64'(itoa_pkg::RECIP10);
  assign tens     = 32'({q_r, 3'b000}) + 32'({q_r, 1'b0});
  assign rem      = mag_r - tens;
  assign top_idx  = sp_r - 1'b1;

  assign push     = step_en && (uword.op == itoa_pkg::OP_REM || uword.op == itoa_pkg::OP_HEX);
  assign push_val = (uword.op == itoa_pkg::OP_HEX) ? mag_r[3:0] : rem[3:0];

  // stack pointer
  always_comb begin
    sp_nxt = sp_r;
    if (step_en) begin
      case (uword.op)
        itoa_pkg::OP_LOAD: sp_nxt = '0;
        itoa_pkg::OP_REM,
        itoa_pkg::OP_HEX:  sp_nxt = sp_r + 1'b1;
        itoa_pkg::OP_POP:  sp_nxt = sp_r - 1'b1;
        default:           sp_nxt = sp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (step_en) begin
      case (uword.op)
        itoa_pkg::OP_LOAD: begin
          if (in_fire) begin
            sel_r <= req_type;
            mag_r <= value;
          end
        end
        itoa_pkg::OP_NEG: mag_r <= 32'd0 - mag_r;
        itoa_pkg::OP_DIV: q_r   <= prod[63:itoa_pkg::RecipShf];
        itoa_pkg::OP_REM: mag_r <= 32'(q_r);
        itoa_pkg::OP_HEX: mag_r <= {4'd0, mag_r[31:4]};
        default: ;
      endcase
    end
    if (push) begin
      stk_r[sp_r] <= push_val;
    end
  end

  // flags for jump conditions
  assign flags.is_hex = sel_r[1];
  assign flags.is_neg = (sel_r == itoa_pkg::FMT_SDEC) && mag_r[31];
  assign flags.mag_nz = (mag_r != 32'd0);
  assign flags.q_nz   = (q_r != '0);
  assign flags.hex_nz = (mag_r[31:4] != 28'd0);
  assign flags.sp_gt1 = (sp_r > 1);

  // character mux
  always_comb begin
    case (uword.csel)
      itoa_pkg::CS_ZERO:  char_sel = itoa_pkg::CH_ZERO;
      itoa_pkg::CS_X:     char_sel = itoa_pkg::CH_X;
      itoa_pkg::CS_MINUS: char_sel = itoa_pkg::CH_MINUS;
      itoa_pkg::CS_SPACE: char_sel = itoa_pkg::CH_SPACE;
      itoa_pkg::CS_DIGIT: char_sel = itoa_pkg::digit_char(stk_r[top_idx]);
      default:            char_sel = itoa_pkg::CH_SPACE;
    endcase
  end

  assign sp_o = sp_r;

endmodule
`default_nettype wire

// ===== hw/rtl/int_to_ascii_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_ascii_formatter - 32-bit value to ASCII decimal or hex characters
// Microcoded sequencer over a divide-by-ten datapath with a digit stack.
// ----------------------------------------------------------------------------
// Takes one request (format, value) and sends its characters one per item,
// last set on the trailing space. The block handles one request at a time and
// is ready only while the sequencer sits in its idle step. A decimal value
// takes two steps per digit through the reciprocal divide-by-ten unit and one
// step per digit to pop the stack, with a minus sign sent by the negate step;
// hex takes one nibble shift and one pop per digit. A single output register
// lets the sequencer keep working while a character waits.
module int_to_ascii_formatter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itoa_in_if.sink    in_ch,
  itoa_out_if.source out_ch
);

  logic [itoa_pkg::StepW-1:0] step_r;
  logic [itoa_pkg::StepW-1:0] step_nxt;
  itoa_pkg::uword_t           uword;
  itoa_pkg::dp_flags_t        flags;
  logic [7:0]                 char_sel;
  logic [itoa_pkg::SpW-1:0]   sp;
  logic                       out_busy;
  logic                       emit;
  logic                       step_en;
  logic                       in_fire;
  logic                       cond_hit;
  logic                       jump;
  logic                       out_valid_r;
  logic [7:0]                 char_r;
  logic                       last_r;

  itoa_ucode_rom u_rom (
    .step  (step_r),
    .uword (uword)
  );

  itoa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .in_fire  (in_fire),
    .req_type (in_ch.req_type),
    .value    (in_ch.value),
    .uword    (uword),
    .flags    (flags),
    .char_sel (char_sel),
    .sp_o     (sp)
  );

  // handshake and step enable
  assign in_ch.ready = (step_r == itoa_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid_r && !out_ch.ready;
  assign emit        = (uword.csel != itoa_pkg::CS_NONE);
  assign step_en     = !(emit && out_busy);

  // jump condition select
  always_comb begin
    case (uword.cond)
      itoa_pkg::C_NEVER:  cond_hit = 1'b0;
      itoa_pkg::C_ALWAYS: cond_hit = 1'b1;
      itoa_pkg::C_INVAL:  cond_hit = in_ch.valid;
      itoa_pkg::C_HEX:    cond_hit = flags.is_hex;
      itoa_pkg::C_NEG:    cond_hit = flags.is_neg;
      itoa_pkg::C_MAGNZ:  cond_hit = flags.mag_nz;
      itoa_pkg::C_QNZ:    cond_hit = flags.q_nz;
      itoa_pkg::C_HNZ:    cond_hit = flags.hex_nz;
      itoa_pkg::C_SPGT1:  cond_hit = flags.sp_gt1;
      default:            cond_hit = 1'b0;
    endcase
  end

  assign jump = cond_hit ^ uword.inv;

  // step counter
  always_comb begin
    step_nxt = step_r;
    if (step_en) begin
      step_nxt = jump ? uword.target : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= itoa_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && step_en) begin
      char_r <= char_sel;
      last_r <= uword.last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = char_r;
  assign out_ch.last     = last_r;

`ifndef ASSERT_OFF
  // digit stack never overflows
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp <= itoa_pkg::StackDepth)
    else $error("digit stack pointer out of range");

  // every run drains the stack before returning to idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == itoa_pkg::ST_IDLE |-> sp == '0)
    else $error("digit stack not empty at idle");

  // the last character sends the sequencer back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && step_en && uword.last) |=> step_r == itoa_pkg::ST_IDLE)
    else $error("sequencer not idle after last character");
`endif

endmodule
`default_nettype wire

// ===== dv/int_to_ascii_formatter_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_ascii_formatter_test - self-checking bench for the ASCII formatter
// Sends format/value requests with random gaps and checks every character
// and its last flag against a predictor of signed decimal, unsigned decimal
// and hex output, while the character side stalls at random.
// ----------------------------------------------------------------------------
module int_to_ascii_formatter_test;

  // selector 3 has its high bit set and prints as hex
  localparam logic [1:0] FMT_HEX_ALT = 2'd3;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned TailCycles = 40;

  typedef struct {
    logic [1:0]  fmt;
    logic [31:0] value;
    bit          drain;   // wait for all characters before sending
  } request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  int_to_ascii_formatter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  request_t    request_queue[$];
  char_item_t  expected_chars[$];
  int unsigned total_requests;
  int unsigned requests_accepted;
  int unsigned error_count;
  int unsigned gap_left;
  int unsigned quiet_items;
  int unsigned stall_left;
  int unsigned calm_left;
  int unsigned idle_cycles;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void expect_char(input logic [7:0] ch, input logic last);
    char_item_t item;
    item.ch = ch;
    item.last = last;
    expected_chars.push_back(item);
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = itoa_pkg::CH_ZERO + 8'(d);
    end else begin
      c = CH_UPPER_A + 8'(d - 4'd10);
    end
    return c;
  endfunction

  // digits of a nonzero magnitude, most significant first
  function automatic void expect_digits(input logic [31:0] mag, input logic [31:0] radix);
    logic [7:0] digits[12];
    int         count;
    logic [31:0] rest;
    count = 0;
    rest = mag;
    while (rest != 32'd0) begin
      digits[count] = ascii_digit(4'(rest % radix));
      count++;
      rest = rest / radix;
    end
    while (count > 0) begin
      count--;
      expect_char(digits[count], 1'b0);
    end
  endfunction

  function automatic void predict_chars(input logic [1:0] fmt, input logic [31:0] value);
    logic [31:0] mag;
    if (fmt[1]) begin
      expect_char(itoa_pkg::CH_ZERO, 1'b0);
      expect_char(itoa_pkg::CH_X, 1'b0);
      if (value == 32'd0) begin
        expect_char(itoa_pkg::CH_ZERO, 1'b0);
      end else begin
        expect_digits(value, 32'd16);
      end
    end else begin
      mag = value;
      if (fmt == itoa_pkg::FMT_SDEC && value[31]) begin
        expect_char(itoa_pkg::CH_MINUS, 1'b0);
        mag = ~value + 32'd1;
      end
      // zero prints as space, '0'
      if (mag == 32'd0) begin
        expect_char(itoa_pkg::CH_SPACE, 1'b0);
        expect_char(itoa_pkg::CH_ZERO, 1'b0);
      end else begin
        expect_digits(mag, 32'd10);
      end
    end
    expect_char(itoa_pkg::CH_SPACE, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic add_request(input logic [1:0] fmt, input logic [31:0] value, input bit drain);
    request_t req;
    req.fmt = fmt;
    req.value = value;
    req.drain = drain;
    request_queue.push_back(req);
    total_requests++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t req;
    bit hold;
    bit send;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      quiet_items = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(in_ch.req_type, in_ch.value);
        requests_accepted++;
      end
      hold = in_ch.valid && !in_ch.ready;
      send = 1'b0;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain && expected_chars.size() > 0)) begin
          req = request_queue.pop_front();
          send = 1'b1;
          // occasional runs of back-to-back items
          if (quiet_items > 0) begin
            quiet_items--;
            gap_left = 0;
          end else if ($urandom_range(0, 29) == 0) begin
            quiet_items = 15;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
          end
        end
        in_ch.valid <= send;
        if (send) begin
          in_ch.req_type <= req.fmt;
          in_ch.value <= req.value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // character monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    char_item_t want;
    int unsigned roll;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b", out_ch.char_out, out_ch.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_out !== want.ch) begin
            report_mismatch($sformatf("char_out got %h expected %h", out_ch.char_out, want.ch));
          end
          if (out_ch.last !== want.last) begin
            report_mismatch($sformatf("last got %b expected %b (char %h)",
                                      out_ch.last, want.last, want.ch));
          end
        end
      end
      // random back-pressure
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          calm_left = 40;
          out_ch.ready <= 1'b1;
        end else if (roll < 25) begin
          stall_left = pick_gap();
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] pow10[10];
    logic [31:0] value;
    logic [1:0]  fmt;
    int unsigned roll;
    in_ch.valid = 1'b0;
    in_ch.req_type = itoa_pkg::FMT_SDEC;
    in_ch.value = 32'd0;
    out_ch.ready = 1'b0;
    total_requests = 0;
    requests_accepted = 0;
    error_count = 0;
    idle_cycles = 0;

    pow10[0] = 32'd1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * 32'd10;

    // directed: zeros, extremes, digit count boundaries
    add_request(itoa_pkg::FMT_SDEC, 32'd0, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'd0, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'd0, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'h8000_0000, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'h7FFF_FFFF, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'hFFFF_FFFF, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'h8000_0001, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'd1, 1'b0);
    add_request(itoa_pkg::FMT_SDEC, 32'hFFFF_FFF6, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'hFFFF_FFFF, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'h8000_0000, 1'b1);
    add_request(itoa_pkg::FMT_UDEC, 32'd9, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'd10, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'd1_000_000_000, 1'b0);
    add_request(itoa_pkg::FMT_UDEC, 32'd999_999_999, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'hFFFF_FFFF, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'h8000_0000, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'h0000_000A, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'h0123_4567, 1'b0);
    add_request(itoa_pkg::FMT_HEX, 32'h89AB_CDEF, 1'b0);
    add_request(FMT_HEX_ALT, 32'd0, 1'b0);
    add_request(FMT_HEX_ALT, 32'hDEAD_BEEF, 1'b0);

    // random requests, biased toward boundaries
    for (int i = 0; i < 350; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 3) fmt = itoa_pkg::FMT_SDEC;
      else if (roll < 6) fmt = itoa_pkg::FMT_UDEC;
      else if (roll < 9) fmt = itoa_pkg::FMT_HEX;
      else fmt = FMT_HEX_ALT;
      case ($urandom_range(0, 7))
        0: value = $urandom() >> $urandom_range(0, 31);
        1: value = 32'($urandom_range(0, 20));
        2: value = pow10[$urandom_range(0, 9)] + 32'($urandom_range(0, 2)) - 32'd1;
        3: value = 32'd1 << $urandom_range(0, 31);
        4: value = ~32'($urandom_range(0, 1000)) + 32'd1;
        5: value = 32'h8000_0000 ^ 32'($urandom_range(0, 3));
        default: value = $urandom();
      endcase
      add_request(fmt, value, (i % 90) == 45);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_accepted < total_requests || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (TailCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_if.sv
hw/rtl/itoa_ucode_rom.sv
hw/rtl/itoa_datapath.sv
hw/rtl/int_to_ascii_formatter.sv
dv/int_to_ascii_formatter_test.sv
